// File: rtl/assert_macros.svh
// assertion macros used by the deframer result queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KDS_ASSERT(label, clk_s, rst_s, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define KDS_ASSERT_ALWAYS(label, clk_s, prop, msg) \
	label: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define KDS_ASSERT(label, clk_s, rst_s, prop, msg)
`define KDS_ASSERT_ALWAYS(label, clk_s, prop, msg)
`endif
`endif

// File: rtl/kds_pkg.sv
// types, constants and key tables of the klv set deframer
`timescale 1ns / 1ps
package kds_pkg;
	localparam int KEY_BYTES = 16;
	localparam int MAX_LENGTH_BYTES_DEF = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_REGS = 2;

	localparam logic [0:0] REG_VALIDATE = 1'b0;
	localparam logic [0:0] REG_KEY_MODE = 1'b1;

	localparam logic [7:0] SHORT_KEY_BYTE = 8'h30;
	localparam logic [7:0] LONG_FORM_LIMIT = 8'h80;

	typedef enum logic [1:0] {
		KIND_LOCAL = 2'd0,
		KIND_UNIVERSAL = 2'd1,
		KIND_SECURITY = 2'd2,
		KIND_ELEMENT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_CHECKSUM = 3'd1,
		ST_UNKNOWN_KEY = 3'd2,
		ST_LENGTH_FORM = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [1:0] set_kind;
		logic last_byte;
		logic [2:0] status;
	} result_t;

	// byte of a full key, set 0 local, 1 universal, 2 security universal
	function automatic logic [7:0] set_key_byte(input logic [1:0] set_idx,
		input logic [3:0] pos);
		logic [7:0] k0 [KEY_BYTES];
		logic [7:0] k1 [KEY_BYTES];
		logic [7:0] k2 [KEY_BYTES];
		k0 = '{8'h06, 8'h0E, 8'h2B, 8'h34, 8'h02, 8'h0B, 8'h01, 8'h01,
			8'h0E, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00};
		k1 = '{8'h06, 8'h0E, 8'h2B, 8'h34, 8'h02, 8'h01, 8'h01, 8'h01,
			8'h0E, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01, 8'h00, 8'h00};
		k2 = '{8'h06, 8'h0E, 8'h2B, 8'h34, 8'h02, 8'h01, 8'h01, 8'h01,
			8'h02, 8'h08, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		unique case (set_idx)
			2'd0: return k0[pos];
			2'd1: return k1[pos];
			default: return k2[pos];
		endcase
	endfunction
endpackage

// File: rtl/kds_in_if.sv
// input word channel: one stream byte per word
`timescale 1ns / 1ps
interface kds_in_if;
	logic valid;
	logic ready;
	logic [7:0] stream_byte;
	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

// File: rtl/kds_out_if.sv
// output word channel: one deframed result per word
`timescale 1ns / 1ps
interface kds_out_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic [1:0] set_kind;
	logic last_byte;
	logic [2:0] status;
	modport source (output valid, output data_byte, output set_kind, output last_byte,
		output status, input ready);
	modport sink (input valid, input data_byte, input set_kind, input last_byte,
		input status, output ready);
endinterface

// File: rtl/kds_queue.sv
// result queue between the parser and the output channel
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kds_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input kds_pkg::result_t push_word,
	output logic full,
	output logic pop_valid,
	input logic pop_ready,
	output kds_pkg::result_t pop_word
);
	import kds_pkg::*;
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	result_t mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic pop;

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop = pop_valid && pop_ready;
	assign pop_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`KDS_ASSERT(a_no_push_full, clk, arst_n, !(push && full && !pop), "push into full queue")
	`KDS_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(QUEUE_DEPTH), "queue count overflow")
	`KDS_ASSERT(a_ptr_gap, clk, arst_n, (AW'(wr_ptr_q - rd_ptr_q) == AW'(count_q)), "pointer gap")
	`KDS_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !pop_valid || arst_n, "not empty after reset")
endmodule

// File: rtl/kds_parser.sv
// key, length and payload parser with running checksum
`timescale 1ns / 1ps
module kds_parser #(
	parameter int MAX_LENGTH_BYTES = kds_pkg::MAX_LENGTH_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] stream_byte,
	input logic validate_checksum,
	input logic key_mode,
	output logic res_valid,
	output kds_pkg::result_t res_word
);
	import kds_pkg::*;
	localparam int LW = $clog2(MAX_LENGTH_BYTES + 1);

	typedef enum logic [3:0] {
		PH_KEY = 4'b0001,
		PH_LEN_FLAG = 4'b0010,
		PH_LEN_BYTES = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

	phase_t phase_q, phase_d;
	logic [3:0] pos_q, pos_d;
	logic [3:0] flags_q, flags_d;
	logic [LW-1:0] left_q, left_d;
	logic [31:0] rem_q, rem_d;
	logic [1:0] kind_q, kind_d;
	logic [15:0] sum_q, sum_d;
	logic par_q, par_d;
	logic [15:0] tail_q, tail_d;

	logic clr;
	logic [15:0] sum_b, tail_b, sum_add, tail_n;
	logic par_b;
	logic [3:0] flags_m;
	logic [31:0] rem_new, rem_dec;
	logic [LW-1:0] left_dec;

	always_comb begin
		clr = (phase_q == PH_KEY) && (pos_q == '0);
		sum_b = clr ? '0 : sum_q;
		tail_b = clr ? '0 : tail_q;
		par_b = clr ? 1'b0 : par_q;
		sum_add = sum_b + (par_b ? {8'h00, tail_b[15:8]} : {tail_b[15:8], 8'h00});
		tail_n = {tail_b[7:0], stream_byte};
		flags_m = clr ? 4'hF : flags_q;
		for (int k = 0; k < 3; k++) begin
			if (stream_byte != set_key_byte(2'(k), pos_q)) begin
				flags_m[k] = 1'b0;
			end
		end
		if (pos_q < 4'd4 && stream_byte != set_key_byte(2'd0, pos_q)) begin
			flags_m[3] = 1'b0;
		end
		rem_new = {rem_q[23:0], stream_byte};
		rem_dec = rem_q - 32'd1;
		left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;

		phase_d = phase_q;
		pos_d = pos_q;
		flags_d = flags_q;
		left_d = left_q;
		rem_d = rem_q;
		kind_d = kind_q;
		sum_d = sum_q;
		par_d = par_q;
		tail_d = tail_q;
		res_valid = 1'b0;
		res_word = '0;

		unique case (phase_q)
			PH_KEY: begin
				sum_d = sum_b;
				par_d = par_b;
				tail_d = tail_b;
				flags_d = clr ? 4'hF : flags_q;
				if (key_mode) begin
					if (stream_byte != SHORT_KEY_BYTE) begin
						res_valid = 1'b1;
						res_word.status = ST_UNKNOWN_KEY;
						pos_d = '0;
						flags_d = 4'hF;
					end else begin
						tail_d = tail_n;
						kind_d = KIND_LOCAL;
						phase_d = PH_LEN_FLAG;
					end
				end else begin
					tail_d = tail_n;
					if (pos_q >= 4'd2) begin
						sum_d = sum_add;
						par_d = ~par_b;
					end
					flags_d = flags_m;
					if (pos_q == 4'(KEY_BYTES - 1)) begin
						pos_d = '0;
						flags_d = 4'hF;
						phase_d = PH_LEN_FLAG;
						priority if (flags_m[0]) begin
							kind_d = KIND_LOCAL;
						end else if (flags_m[1]) begin
							kind_d = KIND_UNIVERSAL;
						end else if (flags_m[2]) begin
							kind_d = KIND_SECURITY;
						end else if (flags_m[3]) begin
							kind_d = KIND_ELEMENT;
						end else begin
							phase_d = PH_KEY;
							res_valid = 1'b1;
							res_word.status = ST_UNKNOWN_KEY;
						end
					end else begin
						pos_d = pos_q + 1'b1;
					end
				end
			end
			PH_LEN_FLAG: begin
				sum_d = sum_add;
				par_d = ~par_q;
				tail_d = tail_n;
				if (stream_byte <= LONG_FORM_LIMIT) begin
					rem_d = {24'h0, stream_byte};
					if (stream_byte == 8'h00) begin
						res_valid = 1'b1;
						res_word.set_kind = kind_q;
						res_word.last_byte = 1'b1;
						res_word.status = ST_EMPTY;
						phase_d = PH_KEY;
						pos_d = '0;
						flags_d = 4'hF;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else if (stream_byte[6:0] > 7'(MAX_LENGTH_BYTES)) begin
					res_valid = 1'b1;
					res_word.set_kind = kind_q;
					res_word.status = ST_LENGTH_FORM;
					phase_d = PH_KEY;
					pos_d = '0;
					flags_d = 4'hF;
				end else begin
					left_d = LW'(stream_byte[6:0]);
					rem_d = '0;
					phase_d = PH_LEN_BYTES;
				end
			end
			PH_LEN_BYTES: begin
				sum_d = sum_add;
				par_d = ~par_q;
				tail_d = tail_n;
				rem_d = rem_new;
				left_d = left_dec;
				if (left_dec == '0) begin
					if (rem_new == '0) begin
						res_valid = 1'b1;
						res_word.set_kind = kind_q;
						res_word.last_byte = 1'b1;
						res_word.status = ST_EMPTY;
						phase_d = PH_KEY;
						pos_d = '0;
						flags_d = 4'hF;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				sum_d = sum_add;
				par_d = ~par_q;
				tail_d = tail_n;
				rem_d = rem_dec;
				res_valid = 1'b1;
				res_word.data_byte = stream_byte;
				res_word.set_kind = kind_q;
				if (rem_dec == '0) begin
					res_word.last_byte = 1'b1;
					if (validate_checksum && !key_mode && kind_q == KIND_LOCAL
						&& sum_add != tail_n) begin
						res_word.status = ST_CHECKSUM;
					end
					phase_d = PH_KEY;
					pos_d = '0;
					flags_d = 4'hF;
				end
			end
			default: begin
				phase_d = PH_KEY;
				pos_d = '0;
				flags_d = 4'hF;
			end
		endcase
		res_valid = res_valid && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			pos_q <= '0;
			flags_q <= 4'hF;
			left_q <= '0;
			rem_q <= '0;
			kind_q <= KIND_LOCAL;
			sum_q <= '0;
			par_q <= 1'b0;
			tail_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			flags_q <= flags_d;
			left_q <= left_d;
			rem_q <= rem_d;
			kind_q <= kind_d;
			sum_q <= sum_d;
			par_q <= par_d;
			tail_q <= tail_d;
		end
	end
endmodule

// File: rtl/klv_set_deframer.sv
// top level of the klv set deframer
`timescale 1ns / 1ps
// klv set deframer: takes one stream byte per word and sustains one word per
// cycle. the parser (front) classifies each byte as key, length or payload
// combinationally and pushes any result into a four-word queue; the output
// channel (back) drains the queue, so input words keep flowing while results
// wait, and input ready drops only when the queue is full. key and length
// bytes give no result word; payload bytes give one each, the last flagged,
// plus error and empty-set words. configuration writes take effect at once
// and should be made while no set is in flight.
module klv_set_deframer #(
	parameter int MAX_LENGTH_BYTES = kds_pkg::MAX_LENGTH_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	kds_in_if.sink stream,
	kds_out_if.source sets,
	input logic wr_en,
	input logic [0:0] wr_index,
	input logic [0:0] wr_data
);
	import kds_pkg::*;

	// configuration registers
	logic validate_q;
	logic key_mode_q;

	logic accept;
	logic full;
	logic res_valid;
	result_t res_word;
	result_t head_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			validate_q <= 1'b0;
			key_mode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_VALIDATE: validate_q <= wr_data[0];
				REG_KEY_MODE: key_mode_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// input side stalls only on a full queue
	assign stream.ready = !full;
	assign accept = stream.valid && stream.ready;

	kds_parser #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.stream_byte(stream.stream_byte),
		.validate_checksum(validate_q),
		.key_mode(key_mode_q),
		.res_valid(res_valid),
		.res_word(res_word)
	);

	// result words drain to the output channel
	kds_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.push_word(res_word),
		.full(full),
		.pop_valid(sets.valid),
		.pop_ready(sets.ready),
		.pop_word(head_word)
	);

	assign sets.data_byte = head_word.data_byte;
	assign sets.set_kind = head_word.set_kind;
	assign sets.last_byte = head_word.last_byte;
	assign sets.status = head_word.status;
endmodule

// File: bench/kds_tb_if.sv
// testbench copies of the word channel interfaces are not needed; this file holds the bench helper package
`timescale 1ns / 1ps
package kds_tb_pkg;
	import kds_pkg::*;

	// one expected or observed result word
	typedef struct packed {
		logic [7:0] data_byte;
		kind_t set_kind;
		logic last_byte;
		status_t status;
	} frame_word_t;
endpackage

// File: bench/tb_klv_set_deframer.sv
// self-checking bench of the klv set deframer with a behavioral parser model
`timescale 1ns / 1ps
module tb_klv_set_deframer;
	import kds_pkg::*;
	import kds_tb_pkg::*;

	// parser phases of the bench model
	typedef enum logic [1:0] {
		PH_KEY = 2'd0,
		PH_LEN_FLAG = 2'd1,
		PH_LEN_BYTES = 2'd2,
		PH_PAYLOAD = 2'd3
	} parse_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [0:0] wr_index = REG_VALIDATE;
	logic [0:0] wr_data = 1'b0;

	kds_in_if stream ();
	kds_out_if sets ();

	klv_set_deframer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream.sink),
		.sets(sets.source),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model copy of configuration and parser state
	logic cfg_validate;
	logic cfg_short_key;
	parse_phase_t m_phase;
	logic [4:0] m_key_pos;
	logic [3:0] m_match;
	logic [2:0] m_len_left;
	logic [31:0] m_remaining;
	kind_t m_kind;
	logic [15:0] m_sum;
	logic m_parity;
	logic [15:0] m_tail;

	// word stores
	logic [7:0] byte_queue[$];
	frame_word_t deframed_expect[$];

	int mismatches = 0;
	int words_seen = 0;
	int bytes_sent = 0;
	int good_sets = 0;
	bit out_stall_en = 1'b1;

	// reference key bytes, rows local, universal, security
	logic [7:0] key_rom [3][16];
	initial begin
		key_rom[0] = '{8'h06, 8'h0E, 8'h2B, 8'h34, 8'h02, 8'h0B, 8'h01, 8'h01,
			8'h0E, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00};
		key_rom[1] = '{8'h06, 8'h0E, 8'h2B, 8'h34, 8'h02, 8'h01, 8'h01, 8'h01,
			8'h0E, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01, 8'h00, 8'h00};
		key_rom[2] = '{8'h06, 8'h0E, 8'h2B, 8'h34, 8'h02, 8'h01, 8'h01, 8'h01,
			8'h02, 8'h08, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
	end

	function automatic frame_word_t mk_word(logic [7:0] d, kind_t k, logic l, status_t s);
		frame_word_t w;
		w.data_byte = d;
		w.set_kind = k;
		w.last_byte = l;
		w.status = s;
		return w;
	endfunction

	// append one word to the expected stream
	task automatic queue_expected(frame_word_t w);
		deframed_expect.insert(deframed_expect.size(), w);
	endtask

	task automatic model_reset();
		cfg_validate = 1'b0;
		cfg_short_key = 1'b0;
		m_phase = PH_KEY;
		m_key_pos = '0;
		m_match = 4'hF;
		m_len_left = '0;
		m_remaining = '0;
		m_kind = KIND_LOCAL;
		m_sum = '0;
		m_parity = 1'b0;
		m_tail = '0;
	endtask

	// shift a byte into the two-byte tail; the byte leaving the tail joins the sum when add_old is set
	task automatic tail_shift(logic [7:0] b, bit add_old);
		logic [15:0] top;
		top = {8'h00, m_tail[15:8]};
		if (add_old) begin
			m_sum = m_sum + (m_parity ? top : (top << 8));
			m_parity = ~m_parity;
		end
		m_tail = {m_tail[7:0], b};
	endtask

	task automatic restart_search();
		m_phase = PH_KEY;
		m_key_pos = '0;
		m_match = 4'hF;
	endtask

	task automatic length_complete();
		if (m_remaining == 0) begin
			restart_search();
			queue_expected(mk_word(8'h00, m_kind, 1'b1, ST_EMPTY));
		end else begin
			m_phase = PH_PAYLOAD;
		end
	endtask

	// advance the deframer model by one stream byte
	task automatic deframe_byte(logic [7:0] b);
		logic [3:0] pos;
		logic [3:0] f;
		status_t st;
		pos = m_key_pos[3:0];
		case (m_phase)
			PH_KEY: begin
				if (pos == 0) begin
					m_sum = '0;
					m_parity = 1'b0;
					m_tail = '0;
					m_match = 4'hF;
				end
				if (cfg_short_key) begin
					if (b != SHORT_KEY_BYTE) begin
						restart_search();
						queue_expected(mk_word(8'h00, KIND_LOCAL, 1'b0, ST_UNKNOWN_KEY));
					end else begin
						tail_shift(b, 1'b0);
						m_kind = KIND_LOCAL;
						m_phase = PH_LEN_FLAG;
					end
				end else begin
					tail_shift(b, pos >= 2);
					for (int k = 0; k < 3; k++)
						if (b != key_rom[k][pos]) m_match[k] = 1'b0;
					if (pos < 4 && b != key_rom[0][pos]) m_match[3] = 1'b0;
					if (pos == 15) begin
						f = m_match;
						m_key_pos = '0;
						m_match = 4'hF;
						if (f[0]) m_kind = KIND_LOCAL;
						else if (f[1]) m_kind = KIND_UNIVERSAL;
						else if (f[2]) m_kind = KIND_SECURITY;
						else if (f[3]) m_kind = KIND_ELEMENT;
						if (f == 0) begin
							restart_search();
							queue_expected(mk_word(8'h00, KIND_LOCAL, 1'b0,
								ST_UNKNOWN_KEY));
						end else begin
							m_phase = PH_LEN_FLAG;
						end
					end else begin
						m_key_pos = {1'b0, pos} + 5'd1;
					end
				end
			end
			PH_LEN_FLAG: begin
				tail_shift(b, 1'b1);
				// 0x80 counts as a short length of 128
				if (b <= LONG_FORM_LIMIT) begin
					m_remaining = {24'h0, b};
					length_complete();
				end else if (b[6:0] > 7'd4) begin
					restart_search();
					queue_expected(mk_word(8'h00, m_kind, 1'b0, ST_LENGTH_FORM));
				end else begin
					m_len_left = b[2:0];
					m_remaining = '0;
					m_phase = PH_LEN_BYTES;
				end
			end
			PH_LEN_BYTES: begin
				tail_shift(b, 1'b1);
				m_remaining = {m_remaining[23:0], b};
				if (m_len_left != 0) m_len_left = m_len_left - 3'd1;
				if (m_len_left == 0) length_complete();
			end
			default: begin
				tail_shift(b, 1'b1);
				m_remaining = m_remaining - 32'd1;
				if (m_remaining == 0) begin
					st = ST_OK;
					// checksum only on local sets in long key mode
					if (cfg_validate && !cfg_short_key && m_kind == KIND_LOCAL
						&& m_sum != m_tail)
						st = ST_CHECKSUM;
					restart_search();
					queue_expected(mk_word(b, m_kind, 1'b1, st));
				end else begin
					queue_expected(mk_word(b, m_kind, 1'b0, ST_OK));
				end
			end
		endcase
	endtask

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// driver: presents queued bytes, holds each until accepted
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream.valid <= 1'b0;
			stream.stream_byte <= 8'h00;
			in_gap <= 0;
		end else begin
			if (stream.valid && stream.ready) begin
				deframe_byte(stream.stream_byte);
				bytes_sent <= bytes_sent + 1;
			end
			if (!stream.valid || stream.ready) begin
				if (in_gap > 0) begin
					stream.valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (byte_queue.size() > 0) begin
					stream.valid <= 1'b1;
					stream.stream_byte <= byte_queue.pop_front();
					in_gap <= gap_len();
				end else begin
					stream.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure and word-by-word compare
	int out_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		frame_word_t got;
		frame_word_t want;
		if (!arst_n) begin
			sets.ready <= 1'b0;
			out_gap <= 0;
		end else begin
			if (sets.valid && sets.ready) begin
				got = mk_word(sets.data_byte, kind_t'(sets.set_kind), sets.last_byte,
					status_t'(sets.status));
				words_seen <= words_seen + 1;
				if (deframed_expect.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected word: data %02h kind %0d last %0b status %0d",
							got.data_byte, got.set_kind, got.last_byte, got.status);
				end else begin
					want = deframed_expect.pop_front();
					if (got !== want) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display({"word mismatch: expected data %02h kind %0d last %0b ",
								"status %0d, got data %02h kind %0d last %0b status %0d"},
								want.data_byte, want.set_kind, want.last_byte, want.status,
								got.data_byte, got.set_kind, got.last_byte, got.status);
					end
				end
			end
			if (!out_stall_en) begin
				sets.ready <= 1'b1;
			end else if (out_gap > 0) begin
				sets.ready <= 1'b0;
				out_gap <= out_gap - 1;
			end else begin
				sets.ready <= 1'b1;
				out_gap <= gap_len();
			end
		end
	end

	task automatic push_bytes(logic [7:0] b);
		byte_queue.insert(byte_queue.size(), b);
	endtask

	// wait until every byte is taken and every word has arrived, plus drain slack
	task automatic wait_idle();
		while (byte_queue.size() > 0 || stream.valid || deframed_expect.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_VALIDATE) cfg_validate = val;
		else cfg_short_key = val;
	endtask

	// checksum over a local set: everything before the last two bytes
	function automatic logic [15:0] block_sum(ref logic [7:0] buf_q[$]);
		logic [15:0] s;
		s = '0;
		foreach (buf_q[i])
			s = s + (i[0] ? {8'h00, buf_q[i]} : {buf_q[i], 8'h00});
		return s;
	endfunction

	// queue one set: key, BER length in the given form, payload
	task automatic queue_set(int kind_sel, int len, int len_form, bit good_sum);
		logic [7:0] frame[$];
		logic [15:0] s;
		frame = {};
		if (cfg_short_key) begin
			frame.insert(frame.size(), SHORT_KEY_BYTE);
		end else begin
			for (int i = 0; i < 16; i++) begin
				if (kind_sel < 3) frame.insert(frame.size(), key_rom[kind_sel][i]);
				else frame.insert(frame.size(), i < 4 ? key_rom[0][i] : 8'($urandom));
			end
		end
		// len_form 0 short, else long form with that many bytes
		if (len_form == 0) begin
			frame.insert(frame.size(), 8'(len));
		end else begin
			frame.insert(frame.size(), 8'h80 | 8'(len_form));
			for (int i = len_form - 1; i >= 0; i--)
				frame.insert(frame.size(), 8'(len >> (8 * i)));
		end
		for (int i = 0; i < len; i++) frame.insert(frame.size(), 8'($urandom));
		if (good_sum && len >= 2) begin
			frame = frame[0:frame.size() - 3];
			s = block_sum(frame);
			frame.insert(frame.size(), s[15:8]);
			frame.insert(frame.size(), s[7:0]);
		end
		foreach (frame[i]) push_bytes(frame[i]);
		good_sets++;
	endtask

	// random mix: mostly well-formed sets, some noise and broken headers
	task automatic queue_random(int budget);
		int r;
		int len;
		int form;
		while (byte_queue.size() < budget) begin
			r = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 12);
			form = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0;
			if (form == 0 && len > 128) len = 128;
			if (r < 75) begin
				queue_set($urandom_range(0, 3), len, form, $urandom_range(0, 3) != 0);
			end else if (r < 85) begin
				push_bytes(8'($urandom));
			end else if (r < 93) begin
				// valid key followed by an oversized length form
				queue_set(0, 0, 0, 1'b0);
				void'(byte_queue.pop_back());
				push_bytes(8'h80 | 8'($urandom_range(5, 127)));
			end else begin
				// key that breaks somewhere in the middle
				for (int i = 0; i < 16; i++)
					push_bytes(i == 7 ? 8'hFF : key_rom[$urandom_range(0, 2)][i]);
			end
		end
	endtask

	initial begin
		model_reset();
		stream.valid = 1'b0;
		stream.stream_byte = 8'h00;
		sets.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each kind, empty set, 0x80 length, longest length form
		write_reg(REG_VALIDATE, 1'b1);
		write_reg(REG_KEY_MODE, 1'b0);
		out_stall_en = 1'b0;
		queue_set(0, 4, 0, 1'b1);
		queue_set(0, 3, 0, 1'b0);
		queue_set(1, 2, 1, 1'b0);
		queue_set(2, 0, 0, 1'b0);
		queue_set(3, 1, 4, 1'b0);
		queue_set(0, 0, 2, 1'b0);
		queue_set(1, 128, 0, 1'b0);
		queue_set(0, 3, 3, 1'b1);
		push_bytes(8'hFF);
		push_bytes(8'h00);
		queue_set(0, 0, 0, 1'b0);
		void'(byte_queue.pop_back());
		push_bytes(8'h85);
		queue_set(1, 0, 0, 1'b0);
		void'(byte_queue.pop_back());
		push_bytes(8'hFF);
		wait_idle();
		out_stall_en = 1'b1;

		// random phases across every register setting
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_VALIDATE, ph[0]);
			write_reg(REG_KEY_MODE, ph[1]);
			queue_random(140);
			wait_idle();
		end

		$display("stream bytes %0d, set headers %0d, result words %0d",
			bytes_sent, good_sets, words_seen);
		$display("covered all set kinds, both key modes, checksum on and off, length forms 0-4");
		if (mismatches == 0 && deframed_expect.size() == 0) begin
			$display("tb_klv_set_deframer OK");
		end else begin
			$display("%0d mismatches, %0d words missing", mismatches, deframed_expect.size());
			$display("tb_klv_set_deframer NOT OK");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("timeout");
		$display("tb_klv_set_deframer NOT OK");
		$finish;
	end
endmodule
